// ----- hw/rtl/stable_priority_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Stable priority queue assertion macros
// Shared concurrent assertion wrappers for the queue checker.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// explicit clock and active-low reset
`define SPQ_ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// default clock and reset names
`define SPQ_ASSERT(label, prop, msg) \
	`SPQ_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

// ----- hw/rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue package
// Sizes, word types and status codes shared by the queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int PRIO_W = 8;
	localparam int PAY_W  = 16;
	localparam int OCC_W  = 5;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_DEQ   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [PRIO_W-1:0] priority_req;
		logic [PAY_W-1:0]  payload;
	} in_word_t;

	typedef struct packed {
		status_t           status;
		logic [PRIO_W-1:0] out_priority;
		logic [PAY_W-1:0]  out_payload;
		logic [OCC_W-1:0]  occupancy;
		logic              is_empty;
	} out_word_t;

	typedef struct packed {
		logic              valid;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  pay;
	} entry_t;

	typedef struct packed {
		logic              enq;
		logic              deq;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  pay;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/spq_if.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue channels
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface spq_in_if;
	logic             valid;
	logic             ready;
	spq_pkg::in_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface spq_out_if;
	logic              valid;
	logic              ready;
	spq_pkg::out_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- hw/rtl/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded queue sorted by priority, highest first, ties in arrival order.
// ----------------------------------------------------------------------------
// channel | dir | word
// req     | in  | cmd, priority_req, payload
// rsp     | out | status, out_priority, out_payload, occupancy, is_empty
//
// One word per cycle while rsp is not stalled; each word is answered in the cycle after acceptance.
// Every cell compares and shifts in the same cycle, set by the cell chain.
// req is ready while the response register is empty or being drained.
// Reset clears the valid bits and the count; no clearing pass.
// ----------------------------------------------------------------------------
module stable_priority_queue (
	input  logic             clk,
	input  logic             arst_n,
	spq_in_if.sink           req,
	spq_out_if.source        rsp
);

	spq_pkg::entry_t    ent   [spq_pkg::DEPTH];
	logic               lower [spq_pkg::DEPTH];
	spq_pkg::cell_ctl_t ctl;

	logic [spq_pkg::CNT_W-1:0] cnt_q;
	logic [spq_pkg::CNT_W-1:0] cnt_nxt;
	logic                      rsp_valid_q;
	spq_pkg::out_word_t        rsp_data_q;
	spq_pkg::out_word_t        res;
	logic                      accept;
	logic                      full;
	logic                      empty;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (cnt_q == spq_pkg::CNT_W'(spq_pkg::DEPTH));
	assign empty     = (cnt_q == '0);

	assign ctl.enq  = accept && (req.data.cmd == spq_pkg::CMD_ENQ) && !full;
	assign ctl.deq  = accept && (req.data.cmd == spq_pkg::CMD_DEQ) && !empty;
	assign ctl.prio = req.data.priority_req;
	assign ctl.pay  = req.data.payload;

	for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
		spq_pkg::entry_t left_ent;
		spq_pkg::entry_t right_ent;
		logic            left_low;

		if (i == 0) begin : g_head
			assign left_ent = '0;
			assign left_low = 1'b0;
		end else begin : g_body
			assign left_ent = ent[i-1];
			assign left_low = lower[i-1];
		end

		if (i == spq_pkg::DEPTH - 1) begin : g_tail
			assign right_ent = '0;
		end else begin : g_inner
			assign right_ent = ent[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.left      (left_ent),
			.left_lower(left_low),
			.right     (right_ent),
			.cur       (ent[i]),
			.lower     (lower[i])
		);
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (ctl.enq) begin
			cnt_nxt = cnt_q + 1'b1;
		end else if (ctl.deq) begin
			cnt_nxt = cnt_q - 1'b1;
		end

		res = '0;
		if (req.data.cmd == spq_pkg::CMD_ENQ) begin
			res.status = full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQ;
		end else if (empty) begin
			res.status = spq_pkg::ST_EMPTY;
		end else begin
			res.status       = spq_pkg::ST_DEQ;
			res.out_priority = ent[0].prio;
			res.out_payload  = ent[0].pay;
		end
		res.occupancy = spq_pkg::OCC_W'(cnt_nxt);
		res.is_empty  = (cnt_nxt == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_data_q <= res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

// ----- hw/rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One sorted slot: holds, takes the left neighbor, takes the new entry,
// or takes the right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_ctl_t ctl,
	input  spq_pkg::entry_t    left,
	input  logic               left_lower,
	input  spq_pkg::entry_t    right,
	output spq_pkg::entry_t    cur,
	output logic               lower
);

	logic                       valid_q;
	logic [spq_pkg::PRIO_W-1:0] prio_q;
	logic [spq_pkg::PAY_W-1:0]  pay_q;
	spq_pkg::entry_t            nxt;

	assign cur   = '{valid: valid_q, prio: prio_q, pay: pay_q};
	assign lower = !valid_q || (prio_q < ctl.prio);

	always_comb begin
		nxt = cur;
		priority if (ctl.enq && lower) begin
			// first lower slot takes the new entry, the rest shift down
			nxt = left_lower ? left
				: spq_pkg::entry_t'{valid: 1'b1, prio: ctl.prio, pay: ctl.pay};
		end else if (ctl.deq) begin
			nxt = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= nxt.prio;
		pay_q  <= nxt.pay;
	end

endmodule

// ----- hw/rtl/spq_checker.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue checker
// Port-level assertions on the response stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_defines.svh"

module spq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input spq_pkg::out_word_t rsp_data
);

	`SPQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response word changed while stalled")
	`SPQ_ASSERT(a_empty_flag, rsp_valid |-> (rsp_data.is_empty == (rsp_data.occupancy == '0)), "empty flag disagrees with occupancy")
	`SPQ_ASSERT(a_enq_zero, rsp_valid && (rsp_data.status == spq_pkg::ST_ENQ) |-> (rsp_data.out_priority == '0) && (rsp_data.out_payload == '0) && !rsp_data.is_empty, "enqueue word carries data or shows empty")
	`SPQ_ASSERT(a_full_occ, rsp_valid && (rsp_data.status == spq_pkg::ST_FULL) |-> (rsp_data.occupancy == spq_pkg::OCC_W'(spq_pkg::DEPTH)), "full drop with queue not full")
	`SPQ_ASSERT(a_word_answered, req_valid && req_ready |=> rsp_valid, "accepted word not answered next cycle")

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);

// ----- dv/stable_priority_queue_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue testbench
// Drives request words through the valid/ready channels and mirrors the sorted
// queue in a shadow copy. Every response word is checked field by field, in
// order. Runs directed corner cases, then random enqueue/dequeue mixes with
// idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module stable_priority_queue_test;

	localparam int N_WORDS = 1900;

	class queue_checker;
		logic [spq_pkg::PRIO_W-1:0] prio_at[spq_pkg::DEPTH];
		logic [spq_pkg::PAY_W-1:0]  pay_at[spq_pkg::DEPTH];
		int                         held;
		spq_pkg::out_word_t         awaited[$];
		int                         errors;

		function new();
			held = 0;
			errors = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_request(spq_pkg::in_word_t w);
			spq_pkg::out_word_t r;
			int                 slot;
			int                 i;
			r = '0;
			if (w.cmd == spq_pkg::CMD_ENQ) begin
				if (held >= spq_pkg::DEPTH) begin
					r.status = spq_pkg::ST_FULL;
				end else begin
					slot = held;
					for (i = 0; i < held; i++) begin
						if (prio_at[i] < w.priority_req) begin
							slot = i;
							break;
						end
					end
					for (i = held; i > slot; i--) begin
						prio_at[i] = prio_at[i-1];
						pay_at[i] = pay_at[i-1];
					end
					prio_at[slot] = w.priority_req;
					pay_at[slot] = w.payload;
					held++;
					r.status = spq_pkg::ST_ENQ;
				end
			end else begin
				if (held == 0) begin
					r.status = spq_pkg::ST_EMPTY;
				end else begin
					r.status = spq_pkg::ST_DEQ;
					r.out_priority = prio_at[0];
					r.out_payload = pay_at[0];
					for (i = 0; i + 1 < held; i++) begin
						prio_at[i] = prio_at[i+1];
						pay_at[i] = pay_at[i+1];
					end
					held--;
				end
			end
			r.occupancy = held[spq_pkg::OCC_W-1:0];
			r.is_empty = (held == 0);
			awaited.push_back(r);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] seen);
			if (want !== seen) begin
				$error("%s: expected %0d, got %0d", field, want, seen);
				errors++;
			end
		endfunction

		function void check_response(spq_pkg::out_word_t got);
			spq_pkg::out_word_t want;
			if (awaited.size() == 0) begin
				$error("response word with nothing outstanding");
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare("status", 32'(want.status), 32'(got.status));
			compare("out_priority", 32'(want.out_priority), 32'(got.out_priority));
			compare("out_payload", 32'(want.out_payload), 32'(got.out_payload));
			compare("occupancy", 32'(want.occupancy), 32'(got.occupancy));
			compare("is_empty", 32'(want.is_empty), 32'(got.is_empty));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	spq_in_if  req_ch();
	spq_out_if rsp_ch();

	stable_priority_queue uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	queue_checker book;
	int           words_sent;
	bit           calm;
	bit           rsp_hold;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
				book.note_request(req_ch.data);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				book.check_response(rsp_ch.data);
		end
	end

	// response side: ready bursts, stall bursts, one long hold on request
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rsp_hold) begin
				rsp_hold = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (300) @(negedge clk);
			end else if (calm || $urandom_range(0, 2) != 0) begin
				rsp_ch.ready <= 1'b1;
				repeat (calm ? 1 : $urandom_range(1, 30)) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL stable_priority_queue");
		$finish;
	end

	task automatic send_word(spq_pkg::cmd_t c, logic [spq_pkg::PRIO_W-1:0] p,
			logic [spq_pkg::PAY_W-1:0] d);
		spq_pkg::in_word_t w;
		w.cmd = c;
		w.priority_req = p;
		w.payload = d;
		req_ch.valid <= 1'b1;
		req_ch.data <= w;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic idle_req(int n);
		req_ch.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_all_answered();
		req_ch.valid <= 1'b0;
		while (book.pending() != 0) @(negedge clk);
	endtask

	function automatic logic [spq_pkg::PRIO_W-1:0] pick_priority(int style);
		logic [spq_pkg::PRIO_W-1:0] p;
		case (style)
			0: p = spq_pkg::PRIO_W'($urandom_range(0, 255));
			1: begin
				case ($urandom_range(0, 5))
					0: p = 8'd0;
					1: p = 8'd1;
					2: p = 8'd127;
					3: p = 8'd128;
					4: p = 8'd254;
					default: p = 8'd255;
				endcase
			end
			default: p = spq_pkg::PRIO_W'($urandom_range(0, 3));
		endcase
		return p;
	endfunction

	function automatic logic [spq_pkg::PAY_W-1:0] pick_payload();
		return spq_pkg::PAY_W'($urandom_range(0, 65535));
	endfunction

	function automatic spq_pkg::cmd_t pick_cmd(int enq_pct);
		return ($urandom_range(0, 99) < enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
	endfunction

	initial begin
		int run_len;
		int enq_pct;
		int style;
		bit gap_free;
		bit drained_once;
		book = new();
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		words_sent = 0;
		calm = 1'b0;
		rsp_hold = 1'b0;
		drained_once = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// dequeue from empty, extremes, ties, fill to capacity, drop when full, then dequeue
		send_word(spq_pkg::CMD_DEQ, 8'd0, 16'h0000);
		send_word(spq_pkg::CMD_ENQ, 8'd255, 16'hffff);
		send_word(spq_pkg::CMD_ENQ, 8'd0, 16'h0000);
		send_word(spq_pkg::CMD_ENQ, 8'd128, 16'h0001);
		send_word(spq_pkg::CMD_ENQ, 8'd128, 16'h0002);
		send_word(spq_pkg::CMD_ENQ, 8'd128, 16'h0003);
		repeat (11) send_word(spq_pkg::CMD_ENQ, pick_priority(0), pick_payload());
		send_word(spq_pkg::CMD_ENQ, 8'd77, 16'habcd);
		repeat (3) send_word(spq_pkg::CMD_DEQ, 8'hff, 16'hffff);

		// sender pauses for the queue to answer, then the receiver holds off
		wait_all_answered();
		rsp_hold = 1'b1;
		wait (rsp_hold == 1'b0);
		repeat (40) send_word(pick_cmd(85), pick_priority(2), pick_payload());

		while (words_sent < N_WORDS) begin
			run_len = $urandom_range(20, 60);
			style = $urandom_range(0, 2);
			gap_free = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: enq_pct = 25;
				1: enq_pct = 50;
				2: enq_pct = 70;
				default: enq_pct = 90;
			endcase
			if (words_sent >= N_WORDS - 250)
				calm = 1'b1;
			repeat (run_len) begin
				if (!calm && !gap_free && $urandom_range(0, 5) == 0)
					idle_req($urandom_range(1, 12));
				send_word(pick_cmd(enq_pct), pick_priority(style), pick_payload());
			end
			if (!drained_once && words_sent >= N_WORDS / 2) begin
				drained_once = 1'b1;
				wait_all_answered();
			end
		end

		wait_all_answered();
		repeat (10) @(negedge clk);
		if (book.errors == 0)
			$display("PASS stable_priority_queue");
		else
			$display("FAIL stable_priority_queue");
		$finish;
	end

endmodule

// ----- stable_priority_queue.f -----
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_priority_queue.sv
hw/rtl/spq_checker.sv
dv/stable_priority_queue_test.sv
